// ----- rtl/lafifo_pkg.sv -----
package lafifo_pkg;

    // Field widths of the item and result channels.
    localparam int OPCODE_W = 3;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 7;

    // Configuration port geometry: one 32-bit register at byte address 0.
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LINE_MODE = 1'b0;

    // Special characters.
    localparam logic [BYTE_W-1:0] LF_BYTE = 8'h0A;
    localparam logic [BYTE_W-1:0] CR_BYTE = 8'h0D;

    // Operation codes as they arrive on the item channel.
    typedef enum logic [OPCODE_W-1:0] {
        OP_PUT     = 3'd0,
        OP_GET     = 3'd1,
        OP_PEEK    = 3'd2,
        OP_GETLINE = 3'd3,
        OP_FLUSH   = 3'd4,
        OP_STATUS  = 3'd5
    } t_op;

    // Classified command passed from the front end to the back end.
    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  limit;
    } t_cmd;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        B_IDLE,
        B_RD,
        B_GL,
        B_EMIT
    } t_bstate;

endpackage

// ----- rtl/lafifo_in_if.sv -----
interface lafifo_in_if import lafifo_pkg::*;;
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [BYTE_W-1:0]   data_in;
    logic [LEN_W-1:0]    max_len;

    modport source (output valid, output opcode, output data_in, output max_len,
                    input ready);
    modport sink   (input valid, input opcode, input data_in, input max_len,
                    output ready);
endinterface

// ----- rtl/lafifo_out_if.sv -----
interface lafifo_out_if import lafifo_pkg::*; #(
    parameter int DEPTH = 256
);
    localparam int CNT_W = $clog2(DEPTH) + 1;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_out;
    logic              data_valid;
    logic              last;
    logic [LEN_W-1:0]  line_length;
    logic [CNT_W-1:0]  fill_count;
    logic              is_empty;
    logic              is_full;
    logic [CNT_W-1:0]  lines_held;
    logic              line_ready;
    logic              overflow_flag;
    logic              underflow_flag;

    modport source (output valid, output data_out, output data_valid, output last,
                    output line_length, output fill_count, output is_empty,
                    output is_full, output lines_held, output line_ready,
                    output overflow_flag, output underflow_flag, input ready);
    modport sink   (input valid, input data_out, input data_valid, input last,
                    input line_length, input fill_count, input is_empty,
                    input is_full, input lines_held, input line_ready,
                    input overflow_flag, input underflow_flag, output ready);
endinterface

// ----- rtl/lafifo_cfg.sv -----
module lafifo_cfg import lafifo_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic                  o_line_mode
);

    logic                 r_line_mode;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    // Word index of the access; the low two address bits are ignored.
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_mode <= 1'b1;
        end else if (wr_en && (reg_idx == REG_LINE_MODE)) begin
            r_line_mode <= pwdata[0];
        end
    end

    // Read mux.
    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_LINE_MODE: prdata = CFG_DATA_W'(r_line_mode);
            default:       prdata = '0;
        endcase
    end

    assign o_line_mode = r_line_mode;

endmodule

// ----- rtl/lafifo_front.sv -----
module lafifo_front import lafifo_pkg::*; #(
    parameter int MAX_LINE = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lafifo_in_if.sink    i_item,
    output logic         o_cmd_valid,
    output t_cmd         o_cmd,
    input  logic         i_cmd_ready
);

    localparam int QDEPTH = 2;

    t_cmd       r_q [QDEPTH];
    logic       r_wsel;
    logic       r_rsel;
    logic [1:0] r_cnt;
    t_cmd       cls;
    logic       push;
    logic       pop;

    // Classify the incoming item: unused opcodes become status requests and
    // the get-line limit is clamped to the line buffer size.
    always_comb begin
        cls.data  = i_item.data_in;
        cls.limit = (i_item.max_len > LEN_W'(MAX_LINE)) ? LEN_W'(MAX_LINE)
                                                        : i_item.max_len;
        case (i_item.opcode)
            OP_PUT:     cls.op = OP_PUT;
            OP_GET:     cls.op = OP_GET;
            OP_PEEK:    cls.op = OP_PEEK;
            OP_GETLINE: cls.op = OP_GETLINE;
            OP_FLUSH:   cls.op = OP_FLUSH;
            default:    cls.op = OP_STATUS;
        endcase
    end

    assign i_item.ready = (r_cnt != 2'(QDEPTH));
    assign push         = i_item.valid && i_item.ready;
    assign o_cmd_valid  = (r_cnt != 2'd0);
    assign o_cmd        = r_q[r_rsel];
    assign pop          = o_cmd_valid && i_cmd_ready;

    // Two-entry command queue between the front and back ends.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wsel] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsel <= 1'b0;
            r_rsel <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wsel <= ~r_wsel;
            end
            if (pop) begin
                r_rsel <= ~r_rsel;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/lafifo_back.sv -----
module lafifo_back import lafifo_pkg::*; #(
    parameter int DEPTH    = 256,
    parameter int MAX_LINE = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_line_mode,
    input  logic         i_cmd_valid,
    input  t_cmd         i_cmd,
    output logic         o_cmd_ready,
    lafifo_out_if.source o_result
);

    localparam int AW  = $clog2(DEPTH);
    localparam int PW  = AW + 1;
    localparam int LBW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
    localparam int LCW = $clog2(MAX_LINE + 1);

    // Byte store and line buffer.
    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_lb  [MAX_LINE];
    logic [BYTE_W-1:0] r_rdata;
    logic [BYTE_W-1:0] r_lbdata;

    // Control and pointer state.
    t_bstate          r_state, n_state;
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [PW-1:0]    r_lc, n_lc;
    t_op              r_op, n_op;
    logic [LCW-1:0]   r_limit, n_limit;
    logic [LCW-1:0]   r_popped, n_popped;
    logic [LCW-1:0]   r_nbytes, n_nbytes;
    logic             r_last_cr, n_last_cr;
    logic [LCW-1:0]   r_ridx, n_ridx;
    logic             r_lbvalid, n_lbvalid;
    logic [LCW-1:0]   r_ecnt, n_ecnt;

    // Result register.
    logic              r_ovalid;
    logic [BYTE_W-1:0] r_odata;
    logic              r_odv;
    logic              r_olast;
    logic [LEN_W-1:0]  r_olen;
    logic [PW-1:0]     r_ofill;
    logic [PW-1:0]     r_olines;
    logic              r_oovf;
    logic              r_ounf;

    // Datapath controls.
    logic              out_free;
    logic [PW-1:0]     fill;
    logic              q_empty;
    logic              q_full;
    logic [PW-1:0]     n_fill;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic              lb_we;
    logic              lb_re;
    logic              gl_is_lf;
    logic              gl_stop;
    logic              em_consume;
    logic              em_last;
    logic              em_done;
    logic              res_load;
    logic [BYTE_W-1:0] res_data;
    logic              res_dv;
    logic              res_last;
    logic [LEN_W-1:0]  res_len;
    logic              res_ovf;
    logic              res_unf;

    assign out_free = !r_ovalid || o_result.ready;
    assign fill     = r_wp - r_rp;
    assign q_empty  = (fill == '0);
    assign q_full   = (fill == PW'(DEPTH));
    assign n_fill   = n_wp - n_rp;

    // Get-line scan: stop at a line-mode line feed, the limit or an empty queue.
    assign gl_is_lf = i_line_mode && (r_rdata == LF_BYTE);
    assign gl_stop  = gl_is_lf || (LCW'(r_popped + LCW'(1)) == r_limit) ||
                      (PW'(r_rp + PW'(1)) == r_wp);

    // Line emission handshake.
    assign em_consume = r_lbvalid && out_free;
    assign em_last    = (LCW'(r_ecnt + LCW'(1)) == r_nbytes);
    assign em_done    = ((r_nbytes == '0) && out_free) || (em_consume && em_last);

    assign o_cmd_ready = (r_state == B_IDLE) && out_free;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    case (i_cmd.op)
                        OP_GET, OP_PEEK: begin
                            if (!q_empty) n_state = B_RD;
                        end
                        OP_GETLINE: begin
                            if (!q_empty && (i_cmd.limit != '0)) n_state = B_GL;
                        end
                        default: n_state = B_IDLE;
                    endcase
                end
            end
            B_RD: begin
                if (out_free) n_state = B_IDLE;
            end
            B_GL: begin
                if (gl_stop) n_state = B_EMIT;
            end
            B_EMIT: begin
                if (em_done) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Datapath and result generation.
    always_comb begin
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_lc      = r_lc;
        n_op      = r_op;
        n_limit   = r_limit;
        n_popped  = r_popped;
        n_nbytes  = r_nbytes;
        n_last_cr = r_last_cr;
        n_ridx    = r_ridx;
        n_lbvalid = r_lbvalid;
        n_ecnt    = r_ecnt;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = r_rp[AW-1:0];
        lb_we     = 1'b0;
        lb_re     = 1'b0;
        res_load  = 1'b0;
        res_data  = '0;
        res_dv    = 1'b0;
        res_last  = 1'b1;
        res_len   = '0;
        res_ovf   = 1'b0;
        res_unf   = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    n_op    = i_cmd.op;
                    n_limit = LCW'(i_cmd.limit);
                    case (i_cmd.op)
                        OP_PUT: begin
                            res_load = 1'b1;
                            if (q_full) begin
                                res_ovf = 1'b1;
                            end else begin
                                mem_we = 1'b1;
                                n_wp   = r_wp + PW'(1);
                                if (i_line_mode && (i_cmd.data == LF_BYTE) &&
                                    (r_lc < PW'(DEPTH))) begin
                                    n_lc = r_lc + PW'(1);
                                end
                            end
                        end
                        OP_GET, OP_PEEK: begin
                            if (q_empty) begin
                                res_load = 1'b1;
                                res_unf  = 1'b1;
                            end else begin
                                mem_re = 1'b1;
                                if (i_cmd.op == OP_GET) n_rp = r_rp + PW'(1);
                            end
                        end
                        OP_GETLINE: begin
                            if (q_empty || (i_cmd.limit == '0)) begin
                                res_load = 1'b1;
                            end else begin
                                mem_re    = 1'b1;
                                n_popped  = '0;
                                n_nbytes  = '0;
                                n_last_cr = 1'b0;
                            end
                        end
                        OP_FLUSH: begin
                            res_load = 1'b1;
                            n_wp     = '0;
                            n_rp     = '0;
                            n_lc     = '0;
                        end
                        default: res_load = 1'b1;
                    endcase
                end
            end
            B_RD: begin
                if (out_free) begin
                    res_load = 1'b1;
                    res_data = r_rdata;
                    res_dv   = 1'b1;
                    if ((r_op == OP_GET) && i_line_mode && (r_rdata == LF_BYTE) &&
                        (r_lc != '0)) begin
                        n_lc = r_lc - PW'(1);
                    end
                end
            end
            B_GL: begin
                // Pop the byte read last cycle and read ahead at the next slot.
                n_rp      = r_rp + PW'(1);
                n_popped  = r_popped + LCW'(1);
                mem_re    = 1'b1;
                mem_raddr = n_rp[AW-1:0];
                if (gl_is_lf) begin
                    if (r_lc != '0) n_lc = r_lc - PW'(1);
                    // A carriage return right before the line feed is dropped.
                    if ((r_nbytes != '0) && r_last_cr) n_nbytes = r_nbytes - LCW'(1);
                end else begin
                    lb_we     = 1'b1;
                    n_nbytes  = r_nbytes + LCW'(1);
                    n_last_cr = (r_rdata == CR_BYTE);
                end
                n_ridx    = '0;
                n_lbvalid = 1'b0;
                n_ecnt    = '0;
            end
            B_EMIT: begin
                if (r_nbytes == '0) begin
                    res_load = out_free;
                end else begin
                    if (em_consume) begin
                        res_load = 1'b1;
                        res_data = r_lbdata;
                        res_dv   = 1'b1;
                        res_last = em_last;
                        res_len  = em_last ? LEN_W'(r_nbytes) : '0;
                        n_ecnt   = r_ecnt + LCW'(1);
                    end
                    if ((r_ridx != r_nbytes) && (!r_lbvalid || out_free)) begin
                        lb_re     = 1'b1;
                        n_ridx    = r_ridx + LCW'(1);
                        n_lbvalid = 1'b1;
                    end else if (em_consume) begin
                        n_lbvalid = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // Byte store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp[AW-1:0]] <= i_cmd.data;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // Line buffer: filled during the scan, drained during emission.
    always_ff @(posedge i_clk) begin
        if (lb_we) begin
            r_lb[r_nbytes[LBW-1:0]] <= r_rdata;
        end
        if (lb_re) begin
            r_lbdata <= r_lb[r_ridx[LBW-1:0]];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_wp      <= '0;
            r_rp      <= '0;
            r_lc      <= '0;
            r_lbvalid <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_lc      <= n_lc;
            r_lbvalid <= n_lbvalid;
            if (res_load) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Per-item working registers and result payload.
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_limit   <= n_limit;
        r_popped  <= n_popped;
        r_nbytes  <= n_nbytes;
        r_last_cr <= n_last_cr;
        r_ridx    <= n_ridx;
        r_ecnt    <= n_ecnt;
        if (res_load) begin
            r_odata  <= res_data;
            r_odv    <= res_dv;
            r_olast  <= res_last;
            r_olen   <= res_len;
            r_ofill  <= n_fill;
            r_olines <= n_lc;
            r_oovf   <= res_ovf;
            r_ounf   <= res_unf;
        end
    end

    assign o_result.valid          = r_ovalid;
    assign o_result.data_out       = r_odata;
    assign o_result.data_valid     = r_odv;
    assign o_result.last           = r_olast;
    assign o_result.line_length    = r_olen;
    assign o_result.fill_count     = r_ofill;
    assign o_result.is_empty       = (r_ofill == '0);
    assign o_result.is_full        = (r_ofill == PW'(DEPTH));
    assign o_result.lines_held     = r_olines;
    assign o_result.line_ready     = (r_olines != '0);
    assign o_result.overflow_flag  = r_oovf;
    assign o_result.underflow_flag = r_ounf;

endmodule

// ----- rtl/line_aware_byte_fifo_top.sv -----
// Byte FIFO of DEPTH entries (a power of two) that also counts the line feeds
// it holds while line_mode is 1. A two-entry command queue takes items while
// the back end works, so an item is accepted even when a result is waiting.
// Each item yields one or more results; every result carries the fill count,
// line count and flags as they stand after the whole item. Put, flush and
// status give their result straight from the idle state of the back end; get
// and peek pass through a read state, since the byte store has a registered
// read port. For a get-line, the idle state issues the first store read, the
// scan pops one byte a cycle from the store port into a line buffer, and the
// line is then replayed from that buffer one byte a cycle, while the result
// port is not held, after a registered buffer read (a line with no bytes
// gives a single result). The store needs no clearing after reset. line_mode
// is written at byte address 0 of the register port and may only change while
// the block is idle.
module line_aware_byte_fifo_top import lafifo_pkg::*; #(
    parameter int DEPTH    = 256,
    parameter int MAX_LINE = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lafifo_in_if.sink             i_item,
    lafifo_out_if.source          o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int PW = $clog2(DEPTH) + 1;

    logic line_mode;
    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;

    lafifo_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_line_mode (line_mode)
    );

    lafifo_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    lafifo_back #(
        .DEPTH    (DEPTH),
        .MAX_LINE (MAX_LINE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_line_mode (line_mode),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_result    (o_result)
    );

    // The reported fill level never exceeds the store size.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.fill_count <= PW'(DEPTH)))
        else $error("fill count above depth");

    // A result without a byte always closes its item.
    a_nodata_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.data_valid) |-> o_result.last)
        else $error("byte-less result not marked last");

    // A refused put or an empty pop never carries a byte.
    a_flag_nodata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.overflow_flag || o_result.underflow_flag))
        |-> !o_result.data_valid)
        else $error("error flag on a result with data");

    // A line length appears only on the closing result of an item.
    a_len_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.line_length != '0)) |-> o_result.last)
        else $error("line length on a non-final result");

endmodule
